// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Each macro expands to a labeled concurrent assertion on the rising edge of clk.
// The assertion is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_AT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/cscv_pkg.sv =====
// ----------------------------------------------------------------------------
// cscv_pkg
// Shared types and codes for the second-chance victim unit: request and
// response items, operation and status codes, controller states, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cscv_pkg;

	// Frame numbers are six bits wide; the accessed bits cover every number.
	localparam int FID_W  = 6;
	localparam int FID_N  = 64;
	localparam int OP_W   = 2;
	localparam int STS_W  = 2;

	// Operation codes carried by a request.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
	localparam logic [OP_W-1:0] OP_EVICT  = 2'd2;

	// Status codes carried by a response.
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [FID_W-1:0] frame_id;
	} req_item_t;

	typedef struct packed {
		logic [FID_W-1:0] victim_id;
		logic [STS_W-1:0] status;
	} rsp_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_insert;   // append the request frame at the tail
		logic             set_access;  // set the accessed bit of the request frame
		logic             rd_head;     // read the ring entry at the (next) head
		logic             rotate;      // move the head entry to the tail
		logic             clear_hit;   // clear the accessed bit of the head entry
		logic             res_load;    // capture a pending result
		logic             res_victim;  // pending result takes the head entry as victim
		logic [STS_W-1:0] res_status;  // status of the pending result
		logic             load_out;    // copy the pending result to the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic count_full;
		logic hit;         // accessed bit of the entry read at the head
	} sts_t;

endpackage

`default_nettype wire

// ===== design/clock_second_chance_victim_unit.sv =====
// ----------------------------------------------------------------------------
// clock_second_chance_victim_unit
// Second-chance (clock) frame replacement: a ring of tracked frame numbers in
// age order with one accessed bit per frame number. Insert appends at the
// tail, access sets a bit, evict scans from the head and returns a victim.
//
//   Channel  Direction  Handshake              Item
//   req      in         req_valid / req_stall  operation, frame_id
//   rsp      out        rsp_valid / rsp_stall  victim_id, status
//
// Insert, access, the unused code and an evict of an empty ring load the
// pending result on the accepting edge and reach the output register from the
// done state once the output is free; the unit then returns to idle. An evict
// examines k ring entries (1 to fill count + 1), one per cycle through the
// registered read port of the ring memory; its result then takes the same path
// through the done state, and the next request is taken once the unit is idle.
// Reset clears the accessed bits, head and count at once; no clearing pass.
// A request is taken whenever the unit is idle, even while a response waits
// in the output register; the next result then waits for that slot.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_second_chance_victim_unit #(
	parameter int MAX_FRAMES = 64
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	output logic                    req_stall,
	input  cscv_pkg::req_item_t     req_item,
	output logic                    rsp_valid,
	input  wire                     rsp_stall,
	output cscv_pkg::rsp_item_t     rsp_item
);
	import cscv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cscv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.operation (req_item.operation),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cscv_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame_id (req_item.frame_id),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_item (rsp_item)
	);

endmodule

`default_nettype wire

// ===== design/cscv_dp.sv =====
// ----------------------------------------------------------------------------
// cscv_dp
// Datapath of the second-chance victim unit: ring memory of frame numbers,
// head pointer and fill count, accessed bits, pending result and output
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cscv_dp #(
	parameter int MAX_FRAMES = 64
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire [cscv_pkg::FID_W-1:0]   frame_id,
	input  cscv_pkg::cmd_t              cmd,
	output cscv_pkg::sts_t              sts,
	output cscv_pkg::rsp_item_t         rsp_item
);
	import cscv_pkg::*;

	localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam logic [IW-1:0] LAST_POS = IW'(MAX_FRAMES - 1);
	localparam logic [CW:0]   N_WIDE   = (CW + 1)'(MAX_FRAMES);
	localparam logic [CW-1:0] N_COUNT  = CW'(MAX_FRAMES);

	logic [FID_W-1:0] ring_mem [MAX_FRAMES];
	logic [FID_W-1:0] rdata_q;
	logic [IW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [FID_N-1:0] bits_q;
	rsp_item_t        res_q;
	rsp_item_t        rsp_item_q;

	logic [CW:0]      tail_sum;
	logic [IW-1:0]    tail_pos;
	logic [IW-1:0]    head_inc;
	logic             mem_we;
	logic [IW-1:0]    waddr;
	logic [IW-1:0]    raddr;
	logic [FID_W-1:0] wdata;

	// Tail position wrapped by one compare and subtract; next head wraps to zero.
	always_comb begin
		tail_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
		if (tail_sum >= N_WIDE) begin
			tail_pos = IW'(tail_sum - N_WIDE);
		end else begin
			tail_pos = IW'(tail_sum);
		end
		head_inc = (head_q == LAST_POS) ? '0 : head_q + 1'b1;
	end

	// Memory port selection: inserts and rotations write the tail.
	assign mem_we = cmd.wr_insert | cmd.rotate;
	assign waddr  = tail_pos;
	assign wdata  = cmd.rotate ? rdata_q : frame_id;
	assign raddr  = cmd.rotate ? head_inc : head_q;

	// Ring memory with a registered read; a read of the entry being written
	// returns the new value.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[waddr] <= wdata;
		end
		if (cmd.rd_head) begin
			if (mem_we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= ring_mem[raddr];
			end
		end
	end

	// Head pointer, fill count and accessed bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			bits_q  <= '0;
		end else begin
			if (cmd.wr_insert) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.rotate) begin
				head_q <= head_inc;
			end
			if (cmd.set_access) begin
				bits_q[frame_id] <= 1'b1;
			end
			if (cmd.clear_hit) begin
				bits_q[rdata_q] <= 1'b0;
			end
		end
	end

	// Pending result and output register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.victim_id <= cmd.res_victim ? rdata_q : '0;
			res_q.status    <= cmd.res_status;
		end
		if (cmd.load_out) begin
			rsp_item_q <= res_q;
		end
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.count_full = (count_q == N_COUNT);
	assign sts.hit        = bits_q[rdata_q];
	assign rsp_item       = rsp_item_q;

	`ASSERT_AT_CLK(a_count_range, count_q <= N_COUNT, "fill count above ring size")
	`ASSERT_AT_CLK(a_head_range, head_q <= LAST_POS, "head pointer outside ring")
	`ASSERT_NEVER(a_insert_full, cmd.wr_insert && (count_q == N_COUNT), "insert into full ring")
	`ASSERT_NEVER(a_rotate_empty, cmd.rotate && (count_q == '0), "rotation of empty ring")

endmodule

`default_nettype wire

// ===== design/cscv_ctrl.sv =====
// ----------------------------------------------------------------------------
// cscv_ctrl
// Controller of the second-chance victim unit: takes requests, steps the
// eviction scan one ring entry per cycle and hands results to the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cscv_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  wire [cscv_pkg::OP_W-1:0]     operation,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	input  cscv_pkg::sts_t               sts,
	output cscv_pkg::cmd_t               cmd
);
	import cscv_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = req_valid && (state_q == S_IDLE);
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((operation == OP_EVICT) && !sts.count_zero) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (!sts.hit) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (accept) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = STS_OK;
					priority if (operation == OP_INSERT) begin
						if (sts.count_full) begin
							cmd.res_status = STS_FULL;
						end else begin
							cmd.wr_insert = 1'b1;
						end
					end else if (operation == OP_ACCESS) begin
						cmd.set_access = 1'b1;
					end else if (operation == OP_EVICT) begin
						if (sts.count_zero) begin
							cmd.res_status = STS_EMPTY;
						end else begin
							cmd.res_load = 1'b0;
							cmd.rd_head  = 1'b1;
						end
					end else begin
						cmd.res_status = STS_OK;
					end
				end
			end
			S_SCAN: begin
				// The head entry always moves to the tail; a set bit gives it a
				// second chance, a clear bit makes it the victim.
				cmd.rotate = 1'b1;
				if (sts.hit) begin
					cmd.clear_hit = 1'b1;
					cmd.rd_head   = 1'b1;
				end else begin
					cmd.res_load   = 1'b1;
					cmd.res_victim = 1'b1;
					cmd.res_status = STS_OK;
				end
			end
			S_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State and response valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

	`ASSERT_AT_CLK(a_scan_nonempty, (state_q == S_SCAN) |-> !sts.count_zero, "scan of empty ring")
	`ASSERT_AT_CLK(a_rsp_from_done, $rose(rsp_valid_q) |-> $past(state_q == S_DONE), "response outside done state")

endmodule

`default_nettype wire

// ===== bench/cscv_victim_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cscv_victim_monitor
// Watches both channels of the second-chance victim unit. Every accepted
// request is run through a local model of the clock policy, and the
// predicted response is queued. Every accepted response is compared field by
// field with the oldest prediction. The mismatch total and the number of
// outstanding predictions are handed back to the testbench top.
// ----------------------------------------------------------------------------
module cscv_victim_monitor (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	input  wire                 req_stall,
	input  cscv_pkg::req_item_t req_item,
	input  wire                 rsp_valid,
	input  wire                 rsp_stall,
	input  cscv_pkg::rsp_item_t rsp_item,
	output int                  mismatch_count,
	output int                  pending_count
);
	import cscv_pkg::*;

	// Ring depth matches the default size of the unit.
	localparam int RING_DEPTH = 64;
	localparam int REPORT_MAX = 10;

	typedef struct {
		req_item_t cause;
		rsp_item_t result;
	} victim_expect_t;

	// Model state: ring of frame numbers, accessed bits, head and fill level.
	logic [FID_W-1:0] ring_frame [RING_DEPTH];
	logic [FID_N-1:0] accessed;
	int               head;
	int               fill;
	int               faults;
	victim_expect_t   victim_expects [$];

	// Applies one request to the model and returns the response it causes.
	function automatic rsp_item_t predict_clock_result(req_item_t r);
		rsp_item_t        res;
		int               scans;
		logic [FID_W-1:0] f;
		logic             found;
		res.victim_id = '0;
		res.status    = STS_OK;
		found         = 1'b0;
		case (r.operation)
			OP_INSERT: begin
				if (fill >= RING_DEPTH) begin
					res.status = STS_FULL;
				end else begin
					ring_frame[(head + fill) % RING_DEPTH] = r.frame_id;
					fill++;
				end
			end
			OP_ACCESS: begin
				accessed[r.frame_id] = 1'b1;
			end
			OP_EVICT: begin
				if (fill == 0) begin
					res.status = STS_EMPTY;
				end else begin
					// Every examined entry moves to the tail; one full pass clears the bits of all ring entries.
					for (scans = 0; scans <= fill && !found; scans++) begin
						f = ring_frame[head];
						ring_frame[(head + fill) % RING_DEPTH] = f;
						head = (head + 1) % RING_DEPTH;
						if (accessed[f]) begin
							accessed[f] = 1'b0;
						end else begin
							res.victim_id = f;
							found = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Responses are checked before the request of the same edge is queued,
	// since no response can come from a request accepted in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		victim_expect_t oldest;
		if (!arst_n) begin
			accessed = '0;
			head     = 0;
			fill     = 0;
			faults   = 0;
			victim_expects.delete();
			mismatch_count <= 0;
			pending_count  <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (victim_expects.size() == 0) begin
					faults++;
					if (faults <= REPORT_MAX) begin
						$display("monitor: response with none expected: victim %0d status %0d",
							rsp_item.victim_id, rsp_item.status);
					end
				end else begin
					oldest = victim_expects.pop_front();
					if (rsp_item.victim_id !== oldest.result.victim_id ||
							rsp_item.status !== oldest.result.status) begin
						faults++;
						if (faults <= REPORT_MAX) begin
							$display({"monitor: op %0d frame %0d: expected victim %0d status %0d,",
								" got victim %0d status %0d"},
								oldest.cause.operation, oldest.cause.frame_id,
								oldest.result.victim_id, oldest.result.status,
								rsp_item.victim_id, rsp_item.status);
						end
					end
				end
			end
			if (req_valid && !req_stall) begin
				victim_expects.push_back('{req_item, predict_clock_result(req_item)});
			end
			mismatch_count <= faults;
			pending_count  <= victim_expects.size();
		end
	end

endmodule

// ===== bench/clock_second_chance_victim_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_second_chance_victim_unit_tb
// Drives the second-chance victim unit with a short directed sequence and then
// a long random mix of insert, access, evict and unused-code requests, with
// random gaps on the request side and random stalls on the response side. A
// monitor beside the unit predicts and checks every response; this top only
// makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module clock_second_chance_victim_unit_tb;
	import cscv_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int DRAIN_CYCLES    = 200;
	localparam int RANDOM_REQUESTS = 1800;
	localparam int IDLE_PERCENT    = 11;
	localparam int STEADY_FIRST    = 700;
	localparam int STEADY_LAST     = 1000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        rsp_stall = 1'b0;
	req_item_t   req_item  = '0;
	logic        req_stall;
	logic        rsp_valid;
	rsp_item_t   rsp_item;
	int          mismatch_count;
	int          pending_count;
	int          sent      = 0;
	int unsigned cycles    = 0;
	logic        steady;

	// No gaps and no stalls while this stretch of requests goes through.
	assign steady = (sent >= STEADY_FIRST) && (sent < STEADY_LAST);

	always #5 clk = ~clk;

	clock_second_chance_victim_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	cscv_victim_monitor u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_item       (req_item),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp_item       (rsp_item),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// Random response stalls.
	always @(posedge clk) begin
		rsp_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Presents one request after a random gap and returns once it is accepted.
	task automatic send_request(logic [OP_W-1:0] op, logic [FID_W-1:0] fid);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= '{operation: op, frame_id: fid};
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		sent++;
	endtask

	// Random mix. Inserts are rare enough that the ring fills gradually and
	// then stays full, so later inserts hit the full case.
	task automatic run_random(int total);
		int issued;
		int pick;
		int id;
		issued = 0;
		while (issued < total) begin
			pick = $urandom_range(99);
			if (pick < 1) begin
				// Set every accessed bit, then evict: the scan makes a full pass.
				for (id = 0; id < FID_N; id++) begin
					send_request(OP_ACCESS, FID_W'(id));
				end
				send_request(OP_EVICT, FID_W'($urandom_range(FID_N - 1)));
				issued += FID_N + 1;
			end else begin
				if (pick < 13) begin
					send_request(OP_INSERT, FID_W'($urandom_range(FID_N - 1)));
				end else if (pick < 16) begin
					send_request(OP_UNUSED, FID_W'($urandom_range(FID_N - 1)));
				end else if (pick < 58) begin
					send_request(OP_ACCESS, FID_W'($urandom_range(FID_N - 1)));
				end else begin
					send_request(OP_EVICT, FID_W'($urandom_range(FID_N - 1)));
				end
				issued++;
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty ring, unused code, untracked access, duplicates,
		// victims with and without second chances, and a full clearing pass.
		send_request(OP_EVICT,  6'd63);
		send_request(OP_UNUSED, 6'd63);
		send_request(OP_ACCESS, 6'd5);
		send_request(OP_INSERT, 6'd0);
		send_request(OP_EVICT,  6'd0);
		send_request(OP_INSERT, 6'd63);
		send_request(OP_INSERT, 6'd5);
		send_request(OP_INSERT, 6'd0);
		send_request(OP_ACCESS, 6'd63);
		send_request(OP_EVICT,  6'd21);
		send_request(OP_ACCESS, 6'd0);
		send_request(OP_ACCESS, 6'd63);
		send_request(OP_ACCESS, 6'd5);
		send_request(OP_EVICT,  6'd0);
		send_request(OP_INSERT, 6'd42);
		send_request(OP_UNUSED, 6'd0);
		send_request(OP_EVICT,  6'd63);

		run_random(RANDOM_REQUESTS);
		req_valid <= 1'b0;

		// Let every outstanding response arrive, then allow for stragglers.
		@(posedge clk);
		while (pending_count != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
